FILE: rtl/vertical_box_blur_macros.svh
// Assertion macros for the vertical box blur RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef VERTICAL_BOX_BLUR_MACROS_SVH
`define VERTICAL_BOX_BLUR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBV_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBV_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bbv_pkg.sv
// Shared types and constants for the vertical box blur.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbv_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 14;
    localparam int ROW_W  = 12;
    localparam int OCOL_W = 10;
    localparam int IW_W   = 11;
    localparam int IH_W   = 13;
    localparam int IR_W   = 5;
    localparam int WIN_W  = IR_W + 1;

    // Frame limits and parameter defaults.
    localparam int MAX_HEIGHT      = 4096;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_RADIUS  = 31;

    // Configuration register map.
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2
    } reg_idx_t;

    localparam logic [IW_W-1:0] RST_WIDTH  = IW_W'(1024);
    localparam logic [IH_W-1:0] RST_HEIGHT = IH_W'(1024);
    localparam logic [IR_W-1:0] RST_RADIUS = IR_W'(1);

    // Controls from the sequencer to the state memories.
    typedef struct packed {
        logic rd;
        logic wr_sum;
        logic wr_first;
        logic wr_line;
    } mem_ctl_t;

endpackage

FILE: rtl/bbv_div.sv
// Reciprocal divider: divides a window sum by the odd window size 2*radius+1.
// Depends on bbv_pkg for the sum and radius widths.
`timescale 1ns / 1ps

module bbv_div
    import bbv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [IR_W-1:0]  radius,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    // The reciprocal is ceil(2^20 / win); with a 14-bit dividend and a window
    // of at most 63 rows the truncated product equals the exact quotient.
    localparam int RCP_W     = 21;
    localparam int RCP_SHIFT = 20;
    localparam int PROD_W    = SUM_W + RCP_W;

    logic [SUM_W-1:0]  dvd_reg;
    logic [RCP_W-1:0]  rcp_reg, rcp_next;
    logic [SUM_W-1:0]  quo_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] product;

    // Reciprocal of the window size for each radius.
    always_comb
    begin
        case (radius)
            5'd0:    rcp_next = 21'd1048576;
            5'd1:    rcp_next = 21'd349526;
            5'd2:    rcp_next = 21'd209716;
            5'd3:    rcp_next = 21'd149797;
            5'd4:    rcp_next = 21'd116509;
            5'd5:    rcp_next = 21'd95326;
            5'd6:    rcp_next = 21'd80660;
            5'd7:    rcp_next = 21'd69906;
            5'd8:    rcp_next = 21'd61681;
            5'd9:    rcp_next = 21'd55189;
            5'd10:   rcp_next = 21'd49933;
            5'd11:   rcp_next = 21'd45591;
            5'd12:   rcp_next = 21'd41944;
            5'd13:   rcp_next = 21'd38837;
            5'd14:   rcp_next = 21'd36158;
            5'd15:   rcp_next = 21'd33826;
            5'd16:   rcp_next = 21'd31776;
            5'd17:   rcp_next = 21'd29960;
            5'd18:   rcp_next = 21'd28340;
            5'd19:   rcp_next = 21'd26887;
            5'd20:   rcp_next = 21'd25576;
            5'd21:   rcp_next = 21'd24386;
            5'd22:   rcp_next = 21'd23302;
            5'd23:   rcp_next = 21'd22311;
            5'd24:   rcp_next = 21'd21400;
            5'd25:   rcp_next = 21'd20561;
            5'd26:   rcp_next = 21'd19785;
            5'd27:   rcp_next = 21'd19066;
            5'd28:   rcp_next = 21'd18397;
            5'd29:   rcp_next = 21'd17773;
            5'd30:   rcp_next = 21'd17190;
            5'd31:   rcp_next = 21'd16645;
            default: rcp_next = 21'd1048576;
        endcase
    end

    // A 14 by 21 bit product of the registered operands.
    assign product = PROD_W'(dvd_reg) * PROD_W'(rcp_reg);

    // Busy for the one cycle between operand capture and quotient.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    // Operand and quotient registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rcp_reg <= rcp_next;
        end
        if (busy_reg)
        begin
            quo_reg <= product[RCP_SHIFT +: SUM_W];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/bbv_mem.sv
// State memories: per-column running sum and first pixel, and the line store.
// Depends on bbv_pkg for widths and the control struct.
`timescale 1ns / 1ps

module bbv_mem
    import bbv_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int LINE_ROWS = 2 * DEF_MAX_RADIUS + 2,
    parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int AW        = $clog2(LINE_ROWS * MAX_WIDTH)
)
(
    input  logic             clk,
    input  mem_ctl_t         ctl,
    input  logic [CW-1:0]    col_addr,
    input  logic [AW-1:0]    line_rd_addr,
    input  logic [AW-1:0]    line_wr_addr,
    input  logic [SUM_W-1:0] sum_wd,
    input  logic [PIX_W-1:0] first_wd,
    input  logic [PIX_W-1:0] line_wd,
    output logic [SUM_W-1:0] sum_rd,
    output logic [PIX_W-1:0] first_rd,
    output logic [PIX_W-1:0] line_rd
);

    logic [SUM_W-1:0] sum_mem   [MAX_WIDTH];
    logic [PIX_W-1:0] first_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line_mem  [LINE_ROWS * MAX_WIDTH];

    // Column memories share one address for reads and writes.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_sum)
        begin
            sum_mem[col_addr] <= sum_wd;
        end
        if (ctl.wr_first)
        begin
            first_mem[col_addr] <= first_wd;
        end
        if (ctl.rd)
        begin
            sum_rd   <= sum_mem[col_addr];
            first_rd <= first_mem[col_addr];
        end
    end

    // Line store with separate read and write addresses.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_line)
        begin
            line_mem[line_wr_addr] <= line_wd;
        end
        if (ctl.rd)
        begin
            line_rd <= line_mem[line_rd_addr];
        end
    end

endmodule

FILE: rtl/vertical_box_blur.sv
// Vertical box blur top level: configuration port, sequencer and output register.
// Depends on bbv_pkg, bbv_mem, bbv_div and vertical_box_blur_macros.svh.
//
// Pixels enter in raster order; each accepted pixel updates its column's running
// sum in memory and yields zero or more results. A pixel that yields nothing passes
// through the accept step with its memory reads and the update step; one that yields
// a result then passes through the reciprocal divider, operand capture and quotient.
// A pixel of the last row adds radius more results, each by a line-store read, the
// new sum and the divider. A stalled output holds the result in the divider state.
// Input is taken only while no earlier pixel is in work; a finished result waits in
// the output register while the next pixel is accepted.
// Registers: image_width at 0x0, image_height at 0x4, blur_radius at 0x8.
`timescale 1ns / 1ps
`include "vertical_box_blur_macros.svh"

module vertical_box_blur
    import bbv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  blurred,
    output logic [ROW_W-1:0]  out_row,
    output logic [OCOL_W-1:0] out_col,
    output logic              run_last
);

    localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW        = $clog2(LINE_ROWS);
    localparam int AW        = $clog2(LINE_ROWS * MAX_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_DIV  = 5'b00100,
        S_TRD  = 5'b01000,
        S_TSUM = 5'b10000
    } state_t;

    // Slot arithmetic modulo the line store depth in rows.
    function automatic logic [SW-1:0] slot_sub(input logic [SW-1:0] a,
                                               input logic [WIN_W-1:0] b);
        logic [7:0] t;
        t = 8'(a) + 8'(LINE_ROWS) - 8'(b);
        if (t >= 8'(LINE_ROWS))
        begin
            t = t - 8'(LINE_ROWS);
        end
        return SW'(t);
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] a);
        return (32'(a) == LINE_ROWS - 1) ? '0 : SW'(a + 1'b1);
    endfunction

    function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] s,
                                                input logic [CW-1:0] c);
        return AW'(AW'(s) * AW'(MAX_WIDTH) + AW'(c));
    endfunction

    // Configuration registers.
    logic [IW_W-1:0] cfg_width_reg;
    logic [IH_W-1:0] cfg_height_reg;
    logic [IR_W-1:0] cfg_radius_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= RST_WIDTH;
            cfg_height_reg <= RST_HEIGHT;
            cfg_radius_reg <= RST_RADIUS;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_WIDTH:  cfg_width_reg  <= pwdata[IW_W-1:0];
                REG_HEIGHT: cfg_height_reg <= pwdata[IH_W-1:0];
                REG_RADIUS: cfg_radius_reg <= pwdata[IR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  prdata = CFG_DW'(cfg_width_reg);
            REG_HEIGHT: prdata = CFG_DW'(cfg_height_reg);
            REG_RADIUS: prdata = CFG_DW'(cfg_radius_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective frame geometry after clamping.
    logic [IH_W-1:0]  w_eff, h_eff, h_half;
    logic [IR_W-1:0]  r_lim, r_eff;
    logic [WIN_W-1:0] win_eff;

    always_comb
    begin
        w_eff = IH_W'(cfg_width_reg);
        if (w_eff == '0)
        begin
            w_eff = IH_W'(1);
        end
        else if (32'(w_eff) > MAX_WIDTH)
        begin
            w_eff = IH_W'(MAX_WIDTH);
        end
        h_eff = cfg_height_reg;
        if (h_eff == '0)
        begin
            h_eff = IH_W'(1);
        end
        else if (32'(h_eff) > MAX_HEIGHT)
        begin
            h_eff = IH_W'(MAX_HEIGHT);
        end
        h_half  = (h_eff - 1'b1) >> 1;
        r_lim   = (32'(cfg_radius_reg) > MAX_RADIUS) ? IR_W'(MAX_RADIUS) : cfg_radius_reg;
        r_eff   = (IH_W'(r_lim) > h_half) ? IR_W'(h_half) : r_lim;
        win_eff = {r_eff, 1'b1};
    end

    // Sequencer and item registers.
    state_t           state_reg, state_next;
    logic [CW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [SW-1:0]    slot_cnt_reg;
    logic [PIX_W-1:0] p_reg, first_reg;
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg, y_reg;
    logic [SW-1:0]    slot_reg, lslot_reg;
    logic [IR_W-1:0]  r_reg;
    logic [WIN_W-1:0] win_reg;
    logic             last_row_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             in_accept, out_free, out_load, more_tail;
    logic             last_row_now;
    logic [SW-1:0]    leave_slot;
    logic             div_start, div_busy;
    logic [SUM_W-1:0] div_dividend, div_quotient;
    logic [SUM_W-1:0] calc_sum, tail_sum;
    logic [PIX_W-1:0] calc_leave, tail_leave;
    mem_ctl_t         mem_ctl;
    logic [CW-1:0]    mem_col;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [SUM_W-1:0] sum_rd;
    logic [PIX_W-1:0] first_rd, line_rd;

    logic             out_valid_reg;
    logic [PIX_W-1:0] blurred_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [OCOL_W-1:0] out_col_reg;
    logic             run_last_reg;

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign last_row_now = (IH_W'(row_cnt_reg) >= h_eff - 1'b1);
    assign leave_slot   = slot_sub(slot_cnt_reg, win_eff);
    assign out_free     = !out_valid_reg || !out_stall;
    assign more_tail    = last_row_reg && (y_reg != row_reg);
    assign out_load     = (state_reg == S_DIV) && !div_busy && out_free;

    // New running sum for the entering row, and for each tail step.
    always_comb
    begin
        calc_leave = (row_reg >= ROW_W'(win_reg)) ? line_rd : first_rd;
        if (row_reg == '0)
        begin
            calc_sum = SUM_W'(win_reg) * SUM_W'(p_reg);
        end
        else
        begin
            calc_sum = sum_rd + SUM_W'(p_reg) - SUM_W'(calc_leave);
        end
        tail_leave = (y_reg >= ROW_W'(r_reg) + 1'b1) ? line_rd : first_reg;
        tail_sum   = sum_reg + SUM_W'(p_reg) - SUM_W'(tail_leave);
    end

    // Memory controls: reads on accept and tail steps, writes in the update cycle.
    always_comb
    begin
        mem_ctl.rd       = in_accept || (state_reg == S_TRD);
        mem_ctl.wr_sum   = (state_reg == S_CALC);
        mem_ctl.wr_line  = (state_reg == S_CALC);
        mem_ctl.wr_first = (state_reg == S_CALC) && (row_reg == '0);
        mem_col          = (state_reg == S_IDLE) ? col_cnt_reg : col_reg;
        rd_addr          = (state_reg == S_IDLE) ? line_addr(leave_slot, col_cnt_reg)
                                                 : line_addr(lslot_reg, col_reg);
        wr_addr          = line_addr(slot_reg, col_reg);
    end

    // Divider is started from the update cycle or a tail step.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = calc_sum;
        if (state_reg == S_CALC)
        begin
            div_start = (row_reg >= ROW_W'(r_reg));
        end
        else if (state_reg == S_TSUM)
        begin
            div_start    = 1'b1;
            div_dividend = tail_sum;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = div_start ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (out_load)
                begin
                    state_next = more_tail ? S_TRD : S_IDLE;
                end
            end
            S_TRD:
            begin
                state_next = S_TSUM;
            end
            S_TSUM:
            begin
                state_next = S_DIV;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers: state and raster counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            slot_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                if (IH_W'(col_cnt_reg) + 1'b1 >= w_eff)
                begin
                    col_cnt_reg <= '0;
                    if (last_row_now)
                    begin
                        row_cnt_reg  <= '0;
                        slot_cnt_reg <= '0;
                    end
                    else
                    begin
                        row_cnt_reg  <= row_cnt_reg + 1'b1;
                        slot_cnt_reg <= slot_inc(slot_cnt_reg);
                    end
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Item registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_reg        <= pixel;
            col_reg      <= col_cnt_reg;
            row_reg      <= row_cnt_reg;
            slot_reg     <= slot_cnt_reg;
            lslot_reg    <= leave_slot;
            r_reg        <= r_eff;
            win_reg      <= win_eff;
            last_row_reg <= last_row_now;
        end
        if (state_reg == S_CALC)
        begin
            sum_reg   <= calc_sum;
            first_reg <= (row_reg == '0) ? p_reg : first_rd;
            y_reg     <= row_reg - ROW_W'(r_reg);
        end
        if (state_reg == S_TSUM)
        begin
            sum_reg <= tail_sum;
        end
        if (out_load && more_tail)
        begin
            y_reg     <= y_reg + 1'b1;
            lslot_reg <= slot_inc(lslot_reg);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            blurred_reg  <= div_quotient[PIX_W-1:0];
            out_row_reg  <= y_reg;
            out_col_reg  <= OCOL_W'(col_reg);
            run_last_reg <= !more_tail;
        end
    end

    assign out_valid = out_valid_reg;
    assign blurred   = blurred_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign run_last  = run_last_reg;

    bbv_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .LINE_ROWS (LINE_ROWS),
        .CW        (CW),
        .AW        (AW)
    ) u_mem (
        .clk          (clk),
        .ctl          (mem_ctl),
        .col_addr     (mem_col),
        .line_rd_addr (rd_addr),
        .line_wr_addr (wr_addr),
        .sum_wd       (calc_sum),
        .first_wd     (p_reg),
        .line_wd      (p_reg),
        .sum_rd       (sum_rd),
        .first_rd     (first_rd),
        .line_rd      (line_rd)
    );

    bbv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radius   (r_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // A pixel is always followed by its memory update cycle.
    `BBV_ASSERT_NEXT(a_accept_calc, in_accept, state_reg == S_CALC, "accept not followed by update")
    // The divider is never restarted while it is still working.
    `BBV_ASSERT_NOW(a_div_idle, div_start, !div_busy, "divider restarted while busy")
    // A result never overwrites one that is still waiting.
    `BBV_ASSERT_NOW(a_out_free, out_load, out_free, "result loaded over a waiting beat")
    // Tail steps occur only for pixels of the last row.
    `BBV_ASSERT_NOW(a_tail_last, state_reg == S_TRD, last_row_reg, "tail step outside last row")

endmodule
